// ===== sv/grid_rust_spread_dilation_assert.svh =====
// Assertion macros shared by the checker of the rust spread block.
// Plain text macros only, no dependencies.
`ifndef GRID_RUST_SPREAD_DILATION_ASSERT_SVH
`define GRID_RUST_SPREAD_DILATION_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define GRSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define GRSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/grsd_pkg.sv =====
// Shared constants for the rust spread block.
// No dependencies.
`timescale 1ns / 1ps

package grsd_pkg;

	// Fixed row word width and default grid size
	localparam int ROW_W    = 16;
	localparam int GRID_DEF = 16;

	// Configuration port
	localparam int CFG_W    = 16;
	localparam int PDATA_W  = 32;
	localparam int PADDR_W  = 3;

	// Register indexes
	localparam logic REG_NUM_MOVES = 1'b0;

endpackage

// ===== sv/grsd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module grsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/grid_rust_spread_dilation.sv =====
// Rust spread block: load GRID rows, run up to num_moves 4-neighbor spread moves, emit GRID rows.
// Load: one row item per cycle. Compute: one sweep over the rows per move, stopping early once a move
// changes nothing. Emit: each row item passes RAM read, capture and hand-over states in turn.
// Move sweep rate is set by the single read port of the row RAM, one row per cycle.
// Reset clears control state and num_moves; row RAM contents are undefined until loaded.
// Depends on grsd_pkg and grsd_ram.
`timescale 1ns / 1ps

module grid_rust_spread_dilation #(
	parameter int GRID = grsd_pkg::GRID_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [grsd_pkg::PADDR_W-1:0] paddr,
	input  logic [grsd_pkg::PDATA_W-1:0] pwdata,
	output logic [grsd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	// input rows
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [grsd_pkg::ROW_W-1:0]   rust_row,
	input  logic [grsd_pkg::ROW_W-1:0]   wall_row,
	input  logic                         row_last,
	// output rows
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [grsd_pkg::ROW_W-1:0]   out_rust_row,
	output logic [grsd_pkg::ROW_W-1:0]   out_wall_row,
	output logic                         out_last
);

	localparam int RW     = grsd_pkg::ROW_W;
	localparam int AW     = $clog2(GRID);
	localparam int CNT_W  = $clog2(GRID + 1);
	localparam int STEP_W = $clog2(GRID + 2);
	localparam int COLS   = (GRID < RW) ? GRID : RW;
	localparam logic [RW-1:0] COL_MASK = {RW{1'b1}} >> (RW - COLS);

	typedef enum logic [2:0] {
		S_LOAD,
		S_MOVE,
		S_ERD,
		S_ECAP,
		S_EHOLD
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          load_cnt_q;
	logic [STEP_W-1:0]         step_q;
	logic [grsd_pkg::CFG_W-1:0] move_cnt_q;
	logic [grsd_pkg::CFG_W-1:0] num_moves_q;
	logic                      changed_q;
	logic [AW-1:0]             row_q;
	logic                      out_valid_q;
	logic [RW-1:0]             out_rust_q;
	logic [RW-1:0]             out_wall_q;
	logic                      out_last_q;

	// sliding window over the move sweep
	logic [RW-1:0] prev_q;
	logic [RW-1:0] cur_q;
	logic [RW-1:0] wall_cur_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [2*RW-1:0]     ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [2*RW-1:0]     ram_rdata;

	logic          in_acc;
	logic          cfg_wr;
	logic [RW-1:0] next_row;
	logic [RW-1:0] nb;
	logic [RW-1:0] nv;
	logic          row_changed;
	logic          step_has_data;
	logic          step_writes;
	logic          step_end;

	// Row RAM: {wall, rust} per row
	grsd_ram #(
		.WIDTH (2 * RW),
		.DEPTH (GRID)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == grsd_pkg::REG_NUM_MOVES) ?
		{{(grsd_pkg::PDATA_W - grsd_pkg::CFG_W){1'b0}}, num_moves_q} : '0;

	assign in_ready  = (state_q == S_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign out_rust_row = out_rust_q;
	assign out_wall_row = out_wall_q;
	assign out_last     = out_last_q;

	// Sweep step decode: row k-1 data lands at step k, row k-2 is written at step k
	assign step_has_data = (step_q >= STEP_W'(1)) && (step_q <= STEP_W'(GRID));
	assign step_writes   = (step_q >= STEP_W'(2));
	assign step_end      = (step_q == STEP_W'(GRID + 1));

	// One cross-shaped dilation step on the row in the window
	assign next_row    = step_has_data ? ram_rdata[RW-1:0] : '0;
	assign nb          = (cur_q << 1) | (cur_q >> 1) | prev_q | next_row;
	assign nv          = (cur_q | (nb & ~wall_cur_q)) & COL_MASK;
	assign row_changed = (nv != cur_q);

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			S_LOAD: begin
				if (in_acc && (load_cnt_q < CNT_W'(GRID))) begin
					ram_we    = 1'b1;
					ram_waddr = load_cnt_q[AW-1:0];
					ram_wdata = {wall_row & COL_MASK, rust_row & COL_MASK};
				end
			end
			S_MOVE: begin
				if (step_q < STEP_W'(GRID)) begin
					ram_raddr = step_q[AW-1:0];
				end
				if (step_writes) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(step_q - STEP_W'(2));
					ram_wdata = {wall_cur_q, nv};
				end
			end
			S_ERD: begin
				ram_raddr = row_q;
			end
			default: begin
			end
		endcase
	end

	// Window registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_MOVE) begin
			if (step_q == '0) begin
				cur_q <= '0;
			end else begin
				prev_q     <= cur_q;
				cur_q      <= next_row;
				wall_cur_q <= ram_rdata[2*RW-1:RW];
			end
		end
	end

	// Control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			load_cnt_q  <= '0;
			step_q      <= '0;
			move_cnt_q  <= '0;
			num_moves_q <= '0;
			changed_q   <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			out_rust_q  <= '0;
			out_wall_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == grsd_pkg::REG_NUM_MOVES)) begin
				num_moves_q <= pwdata[grsd_pkg::CFG_W-1:0];
			end
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (load_cnt_q < CNT_W'(GRID)) begin
							load_cnt_q <= load_cnt_q + CNT_W'(1);
						end
						if (row_last) begin
							step_q     <= '0;
							move_cnt_q <= '0;
							row_q      <= '0;
							state_q    <= (num_moves_q == '0) ? S_ERD : S_MOVE;
						end
					end
				end
				S_MOVE: begin
					if (step_q == '0) begin
						changed_q <= 1'b0;
					end else if (step_writes && row_changed) begin
						changed_q <= 1'b1;
					end
					if (step_end) begin
						step_q <= '0;
						// stop at the move count or once a move leaves the grid unchanged
						if (!(changed_q || row_changed) ||
							(move_cnt_q + grsd_pkg::CFG_W'(1) == num_moves_q)) begin
							row_q   <= '0;
							state_q <= S_ERD;
						end else begin
							move_cnt_q <= move_cnt_q + grsd_pkg::CFG_W'(1);
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_ERD: begin
					state_q <= S_ECAP;
				end
				S_ECAP: begin
					out_rust_q  <= ram_rdata[RW-1:0];
					out_wall_q  <= ram_rdata[2*RW-1:RW];
					out_last_q  <= (row_q == AW'(GRID - 1));
					out_valid_q <= 1'b1;
					state_q     <= S_EHOLD;
				end
				S_EHOLD: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							load_cnt_q <= '0;
							state_q    <= S_LOAD;
						end else begin
							row_q   <= row_q + AW'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== sv/grsd_checker.sv =====
// Port-level checker for the rust spread block, bound to the top level.
// Depends on grid_rust_spread_dilation_assert.svh and grsd_pkg.
`timescale 1ns / 1ps
`include "grid_rust_spread_dilation_assert.svh"

module grsd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       out_last,
	input logic [grsd_pkg::ROW_W-1:0] out_rust_row,
	input logic [grsd_pkg::ROW_W-1:0] out_wall_row
);

	// loading and emitting never overlap
	`GRSD_ASSERT_NOW(a_load_emit_excl, clk, arst_n, out_valid, !in_ready, "ready while emitting")

	// a stalled result item holds
	`GRSD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_rust_row) && $stable(out_wall_row) && $stable(out_last), "stalled item changed")

	// the last row handed over reopens the load
	`GRSD_ASSERT_NXT(a_last_reopens, clk, arst_n, out_valid && out_ready && out_last, in_ready && !out_valid, "load not reopened after last row")

	// each result item is followed by a gap while the next row is read
	`GRSD_ASSERT_NXT(a_no_back_to_back_out, clk, arst_n, out_valid && out_ready && !out_last, !out_valid, "row items emitted back to back")

endmodule

bind grid_rust_spread_dilation grsd_checker u_grsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_last     (out_last),
	.out_rust_row (out_rust_row),
	.out_wall_row (out_wall_row)
);
